### hdl/sed_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sed_pkg
// Shared types, constants and helper functions of the string escape decoder.
// ----------------------------------------------------------------------------
package sed_pkg;

	// Result kinds.
	localparam logic [1:0] KIND_DATA   = 2'd0;
	localparam logic [1:0] KIND_CLOSED = 2'd1;
	localparam logic [1:0] KIND_UNTERM = 2'd2;

	// Characters with a meaning of their own.
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_BIG_U  = 8'h55;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_A      = 8'h61;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_V      = 8'h76;
	localparam logic [7:0] CH_X      = 8'h78;

	// Decoded values of the simple escapes.
	localparam logic [7:0] ESC_BEL = 8'h07;
	localparam logic [7:0] ESC_BS  = 8'h08;
	localparam logic [7:0] ESC_FF  = 8'h0C;
	localparam logic [7:0] ESC_TAB = 8'h09;
	localparam logic [7:0] ESC_VT  = 8'h0B;

	// Digit limits of the hex escapes.
	localparam logic [3:0] HEX_MAX_X  = 4'd2;
	localparam logic [3:0] HEX_MAX_U4 = 4'd4;
	localparam logic [3:0] HEX_MAX_U8 = 4'd8;

	// UTF-8 range limits and lead/continuation marks.
	localparam logic [31:0] UTF_LIM1 = 32'h0000_0080;
	localparam logic [31:0] UTF_LIM2 = 32'h0000_0800;
	localparam logic [31:0] UTF_LIM3 = 32'h0001_0000;
	localparam logic [31:0] UTF_LIM4 = 32'h0011_0000;
	localparam logic [7:0]  UTF_LEAD2 = 8'hC0;
	localparam logic [7:0]  UTF_LEAD3 = 8'hE0;
	localparam logic [7:0]  UTF_LEAD4 = 8'hF0;
	localparam logic [7:0]  UTF_CONT  = 8'h80;

	// Queue between the front and back parts.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Most results one transaction can cause.
	localparam int MAX_RES = 5;

	typedef enum logic [3:0] {
		MODE_NORMAL = 4'b0001,
		MODE_ESCAPE = 4'b0010,
		MODE_HEX    = 4'b0100,
		MODE_CR     = 4'b1000
	} mode_t;

	// One queued command: the results of one input transaction.
	typedef struct packed {
		logic [MAX_RES-1:0][7:0] bytes;
		logic [2:0]              count;
		logic [1:0]              tkind;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} q_stat_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] d;
	} hex_t;

	typedef struct packed {
		logic [3:0][7:0] b;
		logic [2:0]      n;
	} enc_t;

	function automatic hex_t hex_digit(input logic [7:0] c);
		hex_t r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r.ok = 1'b1;
			r.d  = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r.ok = 1'b1;
			r.d  = c[3:0] + 4'd9;
		end
		return r;
	endfunction

	// Byte 0 of the result goes out first. A \x value is a single raw byte.
	function automatic enc_t utf8_encode(input logic [31:0] v, input logic raw);
		enc_t r;
		r = '0;
		if (raw || v < UTF_LIM1) begin
			r.b[0] = v[7:0];
			r.n    = 3'd1;
		end else if (v < UTF_LIM2) begin
			r.b[0] = UTF_LEAD2 | {3'b000, v[10:6]};
			r.b[1] = UTF_CONT | {2'b00, v[5:0]};
			r.n    = 3'd2;
		end else if (v < UTF_LIM3) begin
			r.b[0] = UTF_LEAD3 | {4'b0000, v[15:12]};
			r.b[1] = UTF_CONT | {2'b00, v[11:6]};
			r.b[2] = UTF_CONT | {2'b00, v[5:0]};
			r.n    = 3'd3;
		end else if (v < UTF_LIM4) begin
			r.b[0] = UTF_LEAD4 | {5'b00000, v[20:18]};
			r.b[1] = UTF_CONT | {2'b00, v[17:12]};
			r.b[2] = UTF_CONT | {2'b00, v[11:6]};
			r.b[3] = UTF_CONT | {2'b00, v[5:0]};
			r.n    = 3'd4;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### hdl/sed_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sed_in_if
// Input channel: one source byte of the literal body per transaction.
// ----------------------------------------------------------------------------
interface sed_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       source_end;

	modport source (output valid, output data_byte, output source_end, input ready);
	modport sink   (input valid, input data_byte, input source_end, output ready);
endinterface
`default_nettype wire

### hdl/sed_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sed_out_if
// Output channel: one decoded byte or end-of-literal result per transaction.
// ----------------------------------------------------------------------------
interface sed_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] kind;
	logic       last;

	modport source (output valid, output out_byte, output kind, output last, input ready);
	modport sink   (input valid, input out_byte, input kind, input last, output ready);
endinterface
`default_nettype wire

### hdl/string_escape_utf8_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// string_escape_utf8_decoder
// Decodes the body of a C-style string literal into bytes, with UTF-8 output
// for universal character names.
// ----------------------------------------------------------------------------
// The block takes one source byte per cycle while its queue is not full and gives
// one result per cycle while the receiver is ready. A source byte that causes
// 0 to 5 results holds the output side until all have gone out; a four-entry
// command queue between the decode front end and the output sequencer absorbs
// such bursts, so input stalls only when that queue is full. An accepted
// byte's first result passes through a queue entry and then the output register.
// Each literal ends with a closed or unterminated result marked last, after
// which the next byte starts a new body.
module string_escape_utf8_decoder (
	input  wire        clk,
	input  wire        arst_n,
	sed_in_if.sink     in_ch,
	sed_out_if.source  out_ch
);

	sed_pkg::cmd_t     wr_cmd;
	sed_pkg::cmd_t     head;
	sed_pkg::q_stat_t  q_stat;
	logic              push;
	logic              pop;

	sed_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.q_stat (q_stat),
		.cmd    (wr_cmd),
		.push   (push)
	);

	sed_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.pop    (pop),
		.rd_cmd (head),
		.stat   (q_stat)
	);

	sed_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.out_ch (out_ch)
	);

endmodule
`default_nettype wire

### hdl/sed_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sed_front
// Front part: accepts source bytes, runs the escape state machine and turns
// each transaction with results into one command holding all of its results.
// ----------------------------------------------------------------------------
module sed_front (
	input  wire               clk,
	input  wire               arst_n,
	sed_in_if.sink            in_ch,
	input  sed_pkg::q_stat_t  q_stat,
	output sed_pkg::cmd_t     cmd,
	output logic              push
);

	sed_pkg::mode_t mode_q, mode_d;
	logic [31:0]    hex_q, hex_d;
	logic [3:0]     taken_q, taken_d;
	logic [3:0]     allowed_q, allowed_d;

	logic [7:0]     b;
	logic           fin;
	logic           accept;
	sed_pkg::hex_t  hd;
	sed_pkg::enc_t  enc;
	logic           do_flush;
	logic [31:0]    flush_v;
	logic           do_plain;
	logic [1:0]     esc_n;
	logic [7:0]     esc_b0;
	logic           p_valid;
	logic [7:0]     p_byte;
	logic [1:0]     p_kind;
	logic [sed_pkg::MAX_RES-1:0][7:0] res;
	logic [2:0]     n;

	assign b           = in_ch.data_byte;
	assign fin         = in_ch.source_end;
	assign in_ch.ready = !q_stat.full;
	assign accept      = in_ch.valid && in_ch.ready;
	assign hd          = sed_pkg::hex_digit(b);

	always_comb begin
		mode_d    = mode_q;
		hex_d     = hex_q;
		taken_d   = taken_q;
		allowed_d = allowed_q;
		do_flush  = 1'b0;
		flush_v   = hex_q;
		do_plain  = 1'b0;
		esc_n     = 2'd0;
		esc_b0    = '0;
		p_valid   = 1'b0;
		p_byte    = '0;
		p_kind    = sed_pkg::KIND_DATA;

		case (mode_q)
			sed_pkg::MODE_ESCAPE: begin
				mode_d = sed_pkg::MODE_NORMAL;
				if (fin) begin
					p_valid = 1'b1;
					p_kind  = sed_pkg::KIND_UNTERM;
				end else begin
					esc_n = 2'd1;
					case (b)
						sed_pkg::CH_A:      esc_b0 = sed_pkg::ESC_BEL;
						sed_pkg::CH_B:      esc_b0 = sed_pkg::ESC_BS;
						sed_pkg::CH_F:      esc_b0 = sed_pkg::ESC_FF;
						sed_pkg::CH_N:      esc_b0 = sed_pkg::CH_LF;
						sed_pkg::CH_R:      esc_b0 = sed_pkg::CH_CR;
						sed_pkg::CH_T:      esc_b0 = sed_pkg::ESC_TAB;
						sed_pkg::CH_V:      esc_b0 = sed_pkg::ESC_VT;
						sed_pkg::CH_BSLASH: esc_b0 = b;
						sed_pkg::CH_SQUOTE: esc_b0 = b;
						sed_pkg::CH_DQUOTE: esc_b0 = b;
						sed_pkg::CH_QMARK:  esc_b0 = b;
						sed_pkg::CH_ZERO:   esc_b0 = sed_pkg::CH_NUL;
						sed_pkg::CH_X, sed_pkg::CH_U, sed_pkg::CH_BIG_U: begin
							esc_n   = 2'd0;
							mode_d  = sed_pkg::MODE_HEX;
							hex_d   = '0;
							taken_d = '0;
							if (b == sed_pkg::CH_X) begin
								allowed_d = sed_pkg::HEX_MAX_X;
							end else if (b == sed_pkg::CH_U) begin
								allowed_d = sed_pkg::HEX_MAX_U4;
							end else begin
								allowed_d = sed_pkg::HEX_MAX_U8;
							end
						end
						sed_pkg::CH_LF: esc_n = 2'd0;
						sed_pkg::CH_CR: begin
							esc_n  = 2'd0;
							mode_d = sed_pkg::MODE_CR;
						end
						default: begin
							// Unknown escape: the backslash and the byte itself.
							esc_n  = 2'd2;
							esc_b0 = sed_pkg::CH_BSLASH;
						end
					endcase
				end
			end
			sed_pkg::MODE_HEX: begin
				if (!fin && hd.ok) begin
					hex_d   = {hex_q[27:0], hd.d};
					taken_d = taken_q + 4'd1;
					if (taken_d >= allowed_q) begin
						do_flush = 1'b1;
						flush_v  = hex_d;
						mode_d   = sed_pkg::MODE_NORMAL;
					end
				end else begin
					// The byte that ends the run is decoded after the value.
					do_flush = 1'b1;
					do_plain = 1'b1;
				end
			end
			sed_pkg::MODE_CR: begin
				mode_d   = sed_pkg::MODE_NORMAL;
				do_plain = fin || (b != sed_pkg::CH_LF);
			end
			default: do_plain = 1'b1;
		endcase

		if (do_plain) begin
			mode_d = sed_pkg::MODE_NORMAL;
			if (fin || b == sed_pkg::CH_NUL) begin
				p_valid = 1'b1;
				p_kind  = sed_pkg::KIND_UNTERM;
			end else if (b == sed_pkg::CH_DQUOTE) begin
				p_valid = 1'b1;
				p_kind  = sed_pkg::KIND_CLOSED;
			end else if (b == sed_pkg::CH_BSLASH) begin
				mode_d = sed_pkg::MODE_ESCAPE;
			end else begin
				p_valid = 1'b1;
				p_byte  = b;
			end
		end
	end

	assign enc = sed_pkg::utf8_encode(flush_v, allowed_q == sed_pkg::HEX_MAX_X);

	always_comb begin
		res = '0;
		n   = '0;
		if (do_flush) begin
			res[3:0] = enc.b;
			n        = enc.n;
		end
		if (esc_n != 2'd0) begin
			res[0] = esc_b0;
			res[1] = b;
			n      = {1'b0, esc_n};
		end
		if (p_valid) begin
			res[n] = p_byte;
			n      = n + 3'd1;
		end
	end

	assign cmd.bytes = res;
	assign cmd.count = n;
	assign cmd.tkind = p_valid ? p_kind : sed_pkg::KIND_DATA;
	assign push      = accept && (n != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= sed_pkg::MODE_NORMAL;
			hex_q     <= '0;
			taken_q   <= '0;
			allowed_q <= '0;
		end else if (accept) begin
			mode_q    <= mode_d;
			hex_q     <= hex_d;
			taken_q   <= taken_d;
			allowed_q <= allowed_d;
		end
	end

endmodule
`default_nettype wire

### hdl/sed_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sed_queue
// Short command queue that lets the front and back parts stall separately.
// ----------------------------------------------------------------------------
module sed_queue (
	input  wire               clk,
	input  wire               arst_n,
	input  logic              push,
	input  sed_pkg::cmd_t     wr_cmd,
	input  logic              pop,
	output sed_pkg::cmd_t     rd_cmd,
	output sed_pkg::q_stat_t  stat
);

	sed_pkg::cmd_t                  mem_q [sed_pkg::QDEPTH];
	logic [sed_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [sed_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [sed_pkg::QCNT_W-1:0]     cnt_q;
	logic                           do_push;
	logic                           do_pop;

	assign stat.full      = (cnt_q == sed_pkg::QCNT_W'(sed_pkg::QDEPTH));
	assign stat.not_empty = (cnt_q != '0);
	assign do_push        = push && !stat.full;
	assign do_pop         = pop && stat.not_empty;
	assign rd_cmd         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == sed_pkg::QPTR_W'(sed_pkg::QDEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == sed_pkg::QPTR_W'(sed_pkg::QDEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### hdl/sed_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sed_back
// Back part: walks the results of the head command one per cycle into the
// output register, while the receiver does not stall it.
// ----------------------------------------------------------------------------
module sed_back (
	input  wire               clk,
	input  wire               arst_n,
	input  sed_pkg::cmd_t     head,
	input  sed_pkg::q_stat_t  q_stat,
	output logic              pop,
	sed_out_if.source         out_ch
);

	logic [2:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic [1:0] kind_q;
	logic       last_q;
	logic       load;
	logic       is_last;

	assign load    = q_stat.not_empty && (!valid_q || out_ch.ready);
	assign is_last = (idx_q == head.count - 3'd1);
	assign pop     = load && is_last;

	assign out_ch.valid    = valid_q;
	assign out_ch.out_byte = byte_q;
	assign out_ch.kind     = kind_q;
	assign out_ch.last     = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= is_last ? 3'd0 : idx_q + 3'd1;
			end else if (out_ch.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= head.bytes[idx_q];
			kind_q <= is_last ? head.tkind : sed_pkg::KIND_DATA;
			last_q <= is_last;
		end
	end

endmodule
`default_nettype wire

### hdl/sed_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sed_checker
// Port-level checks of the decoder output, bound to the top level.
// ----------------------------------------------------------------------------
module sed_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       out_valid,
	input wire       out_ready,
	input wire [7:0] out_byte,
	input wire [1:0] kind,
	input wire       last
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output valid dropped while stalled");

	a_hold_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_byte) && $stable(kind) && $stable(last))
		else $error("output payload changed while stalled");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> kind == sed_pkg::KIND_DATA || kind == sed_pkg::KIND_CLOSED ||
			kind == sed_pkg::KIND_UNTERM)
		else $error("illegal result kind");

	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != sed_pkg::KIND_DATA |-> last && out_byte == 8'h00)
		else $error("end-of-literal result not last or carries a byte");

endmodule

bind string_escape_utf8_decoder sed_checker u_sed_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_byte  (out_ch.out_byte),
	.kind      (out_ch.kind),
	.last      (out_ch.last)
);
`default_nettype wire

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the string escape decoder. Literal bodies are built
// from plain bytes, simple escapes, hex and universal-name escapes, line
// continuations and unknown escapes, mixed with raw noise. A decoder model in
// the bench predicts every result, and each output transaction is checked
// against the oldest prediction under varying sender and receiver idling.
// ----------------------------------------------------------------------------
module tb;

	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_F = 8'h46;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic [7:0] data;
		logic       at_end;
	} src_item_t;

	typedef struct {
		logic [7:0] value;
		logic [1:0] kind;
		logic       last;
	} result_t;

	logic clk;
	logic arst_n;

	sed_in_if  in_ch ();
	sed_out_if out_ch ();

	string_escape_utf8_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	src_item_t pending_q[$];
	result_t   decoded_q[$];
	result_t   burst[$];
	src_item_t item_now;
	result_t   want;
	int        queued_cnt;
	int        fail_cnt;
	int        send_idle_pct;
	int        recv_stall_pct;
	int        hold_left;
	logic      hold_go;

	// Decoder model state.
	sed_pkg::mode_t dec_mode;
	logic [31:0]    acc_value;
	logic [3:0]     digits_seen;
	logic [3:0]     digits_max;

	// ------------------------------------------------------------------
	// Decoder model
	// ------------------------------------------------------------------
	function automatic logic [4:0] nibble_of(input logic [7:0] c);
		if (c >= sed_pkg::CH_ZERO && c <= sed_pkg::CH_ZERO + 8'd9)
			return {1'b1, 4'(c - sed_pkg::CH_ZERO)};
		if (c >= sed_pkg::CH_A && c <= sed_pkg::CH_F)
			return {1'b1, 4'(c - sed_pkg::CH_A + 8'd10)};
		if (c >= CH_UPPER_A && c <= CH_UPPER_F)
			return {1'b1, 4'(c - CH_UPPER_A + 8'd10)};
		return 5'd0;
	endfunction

	task automatic add_result(input logic [7:0] b, input logic [1:0] k);
		result_t r;
		r.value = b;
		r.kind  = k;
		r.last  = 1'b0;
		burst.push_back(r);
	endtask

	task automatic clear_run();
		acc_value   = '0;
		digits_seen = '0;
		digits_max  = '0;
	endtask

	task automatic flush_code_point();
		logic [31:0] v;
		v = acc_value;
		if (digits_max == sed_pkg::HEX_MAX_X || v < sed_pkg::UTF_LIM1) begin
			add_result(v[7:0], sed_pkg::KIND_DATA);
		end else if (v < sed_pkg::UTF_LIM2) begin
			add_result(sed_pkg::UTF_LEAD2 | 8'(v >> 6), sed_pkg::KIND_DATA);
			add_result(sed_pkg::UTF_CONT | {2'b00, v[5:0]}, sed_pkg::KIND_DATA);
		end else if (v < sed_pkg::UTF_LIM3) begin
			add_result(sed_pkg::UTF_LEAD3 | 8'(v >> 12), sed_pkg::KIND_DATA);
			add_result(sed_pkg::UTF_CONT | {2'b00, v[11:6]}, sed_pkg::KIND_DATA);
			add_result(sed_pkg::UTF_CONT | {2'b00, v[5:0]}, sed_pkg::KIND_DATA);
		end else if (v < sed_pkg::UTF_LIM4) begin
			add_result(sed_pkg::UTF_LEAD4 | 8'(v >> 18), sed_pkg::KIND_DATA);
			add_result(sed_pkg::UTF_CONT | {2'b00, v[17:12]}, sed_pkg::KIND_DATA);
			add_result(sed_pkg::UTF_CONT | {2'b00, v[11:6]}, sed_pkg::KIND_DATA);
			add_result(sed_pkg::UTF_CONT | {2'b00, v[5:0]}, sed_pkg::KIND_DATA);
		end
		clear_run();
		dec_mode = sed_pkg::MODE_NORMAL;
	endtask

	task automatic plain_step(input logic [7:0] b, input logic e);
		dec_mode = sed_pkg::MODE_NORMAL;
		if (e || b == sed_pkg::CH_NUL) begin
			clear_run();
			add_result(8'h00, sed_pkg::KIND_UNTERM);
		end else if (b == sed_pkg::CH_DQUOTE) begin
			clear_run();
			add_result(8'h00, sed_pkg::KIND_CLOSED);
		end else if (b == sed_pkg::CH_BSLASH) begin
			dec_mode = sed_pkg::MODE_ESCAPE;
		end else begin
			add_result(b, sed_pkg::KIND_DATA);
		end
	endtask

	task automatic open_run(input logic [3:0] allowed);
		clear_run();
		digits_max = allowed;
		dec_mode   = sed_pkg::MODE_HEX;
	endtask

	task automatic escape_step(input logic [7:0] b, input logic e);
		dec_mode = sed_pkg::MODE_NORMAL;
		if (e) begin
			clear_run();
			add_result(8'h00, sed_pkg::KIND_UNTERM);
		end else begin
			case (b)
				sed_pkg::CH_A: add_result(sed_pkg::ESC_BEL, sed_pkg::KIND_DATA);
				sed_pkg::CH_B: add_result(sed_pkg::ESC_BS, sed_pkg::KIND_DATA);
				sed_pkg::CH_F: add_result(sed_pkg::ESC_FF, sed_pkg::KIND_DATA);
				sed_pkg::CH_N: add_result(sed_pkg::CH_LF, sed_pkg::KIND_DATA);
				sed_pkg::CH_R: add_result(sed_pkg::CH_CR, sed_pkg::KIND_DATA);
				sed_pkg::CH_T: add_result(sed_pkg::ESC_TAB, sed_pkg::KIND_DATA);
				sed_pkg::CH_V: add_result(sed_pkg::ESC_VT, sed_pkg::KIND_DATA);
				sed_pkg::CH_BSLASH, sed_pkg::CH_SQUOTE, sed_pkg::CH_DQUOTE,
				sed_pkg::CH_QMARK: add_result(b, sed_pkg::KIND_DATA);
				sed_pkg::CH_ZERO: add_result(sed_pkg::CH_NUL, sed_pkg::KIND_DATA);
				sed_pkg::CH_X: open_run(sed_pkg::HEX_MAX_X);
				sed_pkg::CH_U: open_run(sed_pkg::HEX_MAX_U4);
				sed_pkg::CH_BIG_U: open_run(sed_pkg::HEX_MAX_U8);
				sed_pkg::CH_LF: ;
				sed_pkg::CH_CR: dec_mode = sed_pkg::MODE_CR;
				default: begin
					add_result(sed_pkg::CH_BSLASH, sed_pkg::KIND_DATA);
					add_result(b, sed_pkg::KIND_DATA);
				end
			endcase
		end
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic e);
		logic [4:0] nib;
		burst = {};
		case (dec_mode)
			sed_pkg::MODE_ESCAPE: escape_step(b, e);
			sed_pkg::MODE_HEX: begin
				nib = e ? 5'd0 : nibble_of(b);
				if (nib[4]) begin
					acc_value   = {acc_value[27:0], nib[3:0]};
					digits_seen = digits_seen + 4'd1;
					if (digits_seen >= digits_max)
						flush_code_point();
				end else begin
					// A byte that ends the run is decoded normally after the flush.
					flush_code_point();
					plain_step(b, e);
				end
			end
			sed_pkg::MODE_CR: begin
				dec_mode = sed_pkg::MODE_NORMAL;
				if (e || b != sed_pkg::CH_LF)
					plain_step(b, e);
			end
			default: plain_step(b, e);
		endcase
		if (burst.size() != 0)
			burst[burst.size() - 1].last = 1'b1;
		foreach (burst[i])
			decoded_q.push_back(burst[i]);
	endtask

	// ------------------------------------------------------------------
	// Stimulus builders
	// ------------------------------------------------------------------
	task automatic push_byte(input logic [7:0] b);
		src_item_t s;
		s.data   = b;
		s.at_end = 1'b0;
		pending_q.push_back(s);
		queued_cnt++;
	endtask

	task automatic push_end();
		src_item_t s;
		s.data   = 8'($urandom_range(0, 255));
		s.at_end = 1'b1;
		pending_q.push_back(s);
		queued_cnt++;
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] d);
		if (d < 4'd10)
			return sed_pkg::CH_ZERO + 8'(d);
		if ($urandom_range(0, 1) == 0)
			return CH_UPPER_A + 8'(d) - 8'd10;
		return sed_pkg::CH_A + 8'(d) - 8'd10;
	endfunction

	function automatic logic known_escape(input logic [7:0] b);
		case (b)
			sed_pkg::CH_A, sed_pkg::CH_B, sed_pkg::CH_F, sed_pkg::CH_N, sed_pkg::CH_R,
			sed_pkg::CH_T, sed_pkg::CH_V, sed_pkg::CH_BSLASH, sed_pkg::CH_SQUOTE,
			sed_pkg::CH_DQUOTE, sed_pkg::CH_QMARK, sed_pkg::CH_ZERO, sed_pkg::CH_X,
			sed_pkg::CH_U, sed_pkg::CH_BIG_U, sed_pkg::CH_LF, sed_pkg::CH_CR:
				return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	task automatic push_plain();
		logic [7:0] b;
		do
			b = 8'($urandom_range(1, 255));
		while (b == sed_pkg::CH_BSLASH || b == sed_pkg::CH_DQUOTE);
		push_byte(b);
	endtask

	// Backslash, the escape letter, then some digits of a value picked so
	// that every UTF-8 length shows up, including values that are too large.
	task automatic push_hex_escape(input logic [7:0] letter, input int allowed);
		logic [31:0] v;
		int k;
		push_byte(sed_pkg::CH_BSLASH);
		push_byte(letter);
		case ($urandom_range(0, 4))
			0: v = $urandom_range(0, 'h7F);
			1: v = $urandom_range('h80, 'h7FF);
			2: v = $urandom_range('h800, 'hFFFF);
			3: v = $urandom_range('h10000, 'h10FFFF);
			default: v = $urandom;
		endcase
		k = ($urandom_range(0, 99) < 70) ? allowed : $urandom_range(0, allowed - 1);
		for (int i = k - 1; i >= 0; i--)
			push_byte(hex_char(v[4*i +: 4]));
	endtask

	task automatic push_simple_escape();
		logic [7:0] c;
		case ($urandom_range(0, 11))
			0: c = sed_pkg::CH_A;
			1: c = sed_pkg::CH_B;
			2: c = sed_pkg::CH_F;
			3: c = sed_pkg::CH_N;
			4: c = sed_pkg::CH_R;
			5: c = sed_pkg::CH_T;
			6: c = sed_pkg::CH_V;
			7: c = sed_pkg::CH_BSLASH;
			8: c = sed_pkg::CH_SQUOTE;
			9: c = sed_pkg::CH_DQUOTE;
			10: c = sed_pkg::CH_QMARK;
			default: c = sed_pkg::CH_ZERO;
		endcase
		push_byte(sed_pkg::CH_BSLASH);
		push_byte(c);
	endtask

	task automatic push_literal();
		int r;
		logic [7:0] b;
		repeat ($urandom_range(3, 12)) begin
			r = $urandom_range(0, 99);
			if (r < 35) begin
				push_plain();
			end else if (r < 50) begin
				push_simple_escape();
			end else if (r < 58) begin
				push_hex_escape(sed_pkg::CH_X, 2);
			end else if (r < 68) begin
				push_hex_escape(sed_pkg::CH_U, 4);
			end else if (r < 80) begin
				push_hex_escape(sed_pkg::CH_BIG_U, 8);
			end else if (r < 86) begin
				push_byte(sed_pkg::CH_BSLASH);
				case ($urandom_range(0, 2))
					0: push_byte(sed_pkg::CH_LF);
					1: push_byte(sed_pkg::CH_CR);
					default: begin
						push_byte(sed_pkg::CH_CR);
						push_byte(sed_pkg::CH_LF);
					end
				endcase
			end else if (r < 94) begin
				do
					b = 8'($urandom_range(0, 255));
				while (known_escape(b));
				push_byte(sed_pkg::CH_BSLASH);
				push_byte(b);
			end else begin
				push_plain();
			end
		end
		r = $urandom_range(0, 99);
		if (r < 70) begin
			push_byte(sed_pkg::CH_DQUOTE);
		end else if (r < 82) begin
			push_byte(sed_pkg::CH_NUL);
		end else if (r < 94) begin
			push_end();
		end else begin
			push_byte(sed_pkg::CH_BSLASH);
			push_end();
		end
	endtask

	task automatic push_noise();
		repeat ($urandom_range(1, 6)) begin
			if ($urandom_range(0, 7) == 0)
				push_end();
			else
				push_byte(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic fill_phase(input int n);
		int target;
		target = queued_cnt + n;
		while (queued_cnt < target) begin
			if ($urandom_range(0, 99) < 15)
				push_noise();
			else
				push_literal();
		end
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		@(negedge clk);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	// Waits until every queued byte has been sent and every predicted result has been seen.
	task automatic drain();
		do
			@(negedge clk);
		while (pending_q.size() != 0 || in_ch.valid || decoded_q.size() != 0);
	endtask

	// ------------------------------------------------------------------
	// Clock, driver, receiver and monitor
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid      <= 1'b0;
			in_ch.data_byte  <= 8'h00;
			in_ch.source_end <= 1'b0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				item_now = pending_q.pop_front();
				in_ch.valid      <= 1'b1;
				in_ch.data_byte  <= item_now.data;
				in_ch.source_end <= item_now.at_end;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_go)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ch.ready <= 1'b0;
		else
			out_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Input transactions are predicted here, before the output check, so the
	// order of the two does not depend on the scheduler.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				decode_byte(in_ch.data_byte, in_ch.source_end);
			if (out_ch.valid && out_ch.ready) begin
				if (decoded_q.size() == 0) begin
					$display("%0t: unexpected result: byte %h kind %0d last %0b", $time,
						out_ch.out_byte, out_ch.kind, out_ch.last);
					fail_cnt++;
				end else begin
					want = decoded_q.pop_front();
					if (out_ch.out_byte !== want.value || out_ch.kind !== want.kind ||
						out_ch.last !== want.last) begin
						$display("%0t: mismatch: expected byte %h kind %0d last %0b, got byte %h kind %0d last %0b",
							$time, want.value, want.kind, want.last,
							out_ch.out_byte, out_ch.kind, out_ch.last);
						fail_cnt++;
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n           = 1'b0;
		in_ch.valid      = 1'b0;
		in_ch.data_byte  = 8'h00;
		in_ch.source_end = 1'b0;
		out_ch.ready     = 1'b0;
		hold_go          = 1'b0;
		send_idle_pct    = 0;
		recv_stall_pct   = 0;
		queued_cnt       = 0;
		fail_cnt         = 0;
		dec_mode         = sed_pkg::MODE_NORMAL;
		clear_run();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: byte extremes, a newline escape, an empty \x, a four-byte
		// code point cut short by the closing quote, CR-LF continuation, an
		// unknown escape, end right after a backslash, an escaped NUL and NUL.
		push_byte(CH_UPPER_A);
		push_byte(8'hFF);
		push_byte(sed_pkg::CH_BSLASH);
		push_byte(sed_pkg::CH_N);
		push_byte(sed_pkg::CH_BSLASH);
		push_byte(sed_pkg::CH_X);
		push_byte(8'h47);
		push_byte(sed_pkg::CH_BSLASH);
		push_byte(sed_pkg::CH_BIG_U);
		push_byte(sed_pkg::CH_ZERO + 8'd1);
		push_byte(CH_UPPER_F);
		push_byte(sed_pkg::CH_ZERO + 8'd6);
		push_byte(sed_pkg::CH_ZERO);
		push_byte(sed_pkg::CH_ZERO);
		push_byte(sed_pkg::CH_DQUOTE);
		push_byte(sed_pkg::CH_BSLASH);
		push_byte(sed_pkg::CH_CR);
		push_byte(sed_pkg::CH_LF);
		push_byte(sed_pkg::CH_BSLASH);
		push_byte(8'h71);
		push_byte(sed_pkg::CH_BSLASH);
		push_end();
		push_byte(sed_pkg::CH_BSLASH);
		push_byte(sed_pkg::CH_NUL);
		push_byte(sed_pkg::CH_NUL);
		drain();

		set_idling(0, 0);
		fill_phase(65);
		drain();
		set_idling(60, 0);
		fill_phase(65);
		drain();
		set_idling(0, 60);
		fill_phase(65);
		drain();
		set_idling(7, 7);
		fill_phase(65);
		drain();

		// Receiver holds off while the sender keeps offering, so the block
		// fills up and stalls its input.
		set_idling(0, 0);
		hold_go = 1'b1;
		@(negedge clk);
		hold_go = 1'b0;
		fill_phase(30);
		drain();

		repeat (20) @(negedge clk);
		if (fail_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#(12 * 250000);
		$display("TB_ERROR");
		$finish;
	end

endmodule

### sim.f
hdl/sed_pkg.sv
hdl/sed_in_if.sv
hdl/sed_out_if.sv
hdl/sed_front.sv
hdl/sed_queue.sv
hdl/sed_back.sv
hdl/string_escape_utf8_decoder.sv
hdl/sed_checker.sv
sim/tb.sv
